[rtl/psrl_pkg.sv]
// ----------------------------------------------------------------------------
// psrl_pkg
// Shared types and constants for the per-source rate limiter: table geometry,
// register indexes and reset values, the table entry layout and the shared
// arithmetic unit's opcodes and result bundle.
// ----------------------------------------------------------------------------
package psrl_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned FILL_W      = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 8;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAN_MS       = 2'd2;

  // Register reset values.
  localparam logic [TIME_W-1:0]  WINDOW_MS_RST    = 32'd5000;
  localparam logic [COUNT_W-1:0] MAX_REQUESTS_RST = 8'd3;
  localparam logic [TIME_W-1:0]  BAN_MS_RST       = 32'd10000;

  // Count limits.
  localparam logic [COUNT_W-1:0] COUNT_ONE = 8'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // One table entry.
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  window_base;
    logic [TIME_W-1:0]  ban_end;
  } entry_t;

  // Table port controls.
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
  } ram_ctl_t;

  // Shared adder operations.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Shared adder result.
  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              borrow;
    logic              zero;
  } alu_res_t;

endpackage

[rtl/per_source_rate_limiter_unit.sv]
// ----------------------------------------------------------------------------
// per_source_rate_limiter_unit
// Per-source fixed window rate limiter with ban, built around a table search
// and one shared add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel (source address and millisecond
//   time stamp) and one decision leaves on the m_axis channel per request.
//   Registers are written through cfg_we_i / cfg_index_i / cfg_data_i while
//   the block is idle; an index beyond the register list is ignored.
//   The block takes one item at a time: s_axis_tready_o is high only while
//   it waits for a request. The table is scanned one entry per cycle through
//   the single read port of the table memory, up to the fill count for an
//   unknown source and up to the matched entry for a known one.
//   The decision waits in an output register until the receiver takes it;
//   a stalled receiver holds the block busy with no loss of the item.
//   Reset empties the table (fill count zero) and restores the register
//   defaults; no clearing pass is needed, entries at or above the fill
//   count are never read.
// ----------------------------------------------------------------------------
module per_source_rate_limiter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request: [31:0] source_address, [63:32] time_ms
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [63:0]                       s_axis_tdata_i,
  // Decision: [0] allowed, [1] newly_banned, [2] untracked, [7:3] zero
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [psrl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [psrl_pkg::TIME_W-1:0]       cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_BAN_CHK,
    ST_AGE,
    ST_WIN_CHK,
    ST_LIMIT_CHK,
    ST_BAN_SET,
    ST_WRITE,
    ST_INSERT,
    ST_OUT
  } state_e;

  state_e                              state_q;
  logic [psrl_pkg::FILL_W-1:0]         fill_q;
  logic [psrl_pkg::FILL_W-1:0]         scan_q;
  logic                                pend_q;
  logic                                out_valid_q;
  logic                                allowed_q;
  logic                                banned_q;
  logic                                untracked_q;

  logic [psrl_pkg::ADDR_W-1:0]         src_q;
  logic [psrl_pkg::TIME_W-1:0]         now_q;
  logic [psrl_pkg::IDX_W-1:0]          hit_idx_q;
  psrl_pkg::entry_t                    ent_q;
  logic [psrl_pkg::TIME_W-1:0]         diff_q;

  logic [psrl_pkg::TIME_W-1:0]         window_q;
  logic [psrl_pkg::COUNT_W-1:0]        max_q;
  logic [psrl_pkg::TIME_W-1:0]         ban_ms_q;

  psrl_pkg::alu_op_e                   alu_op;
  logic [psrl_pkg::TIME_W-1:0]         alu_a;
  logic [psrl_pkg::TIME_W-1:0]         alu_b;
  psrl_pkg::alu_res_t                  alu_res;

  psrl_pkg::ram_ctl_t                  ram_ctl;
  psrl_pkg::entry_t                    ram_wdata;
  psrl_pkg::entry_t                    ram_rdata;
  psrl_pkg::entry_t                    new_entry;

  logic                                match;
  logic                                scan_more;
  logic                                table_full;
  logic [psrl_pkg::COUNT_W-1:0]        count_inc;

  assign match      = pend_q && alu_res.zero;
  assign scan_more  = (scan_q < fill_q);
  assign table_full = (fill_q == psrl_pkg::FILL_W'(psrl_pkg::TABLE_DEPTH));
  assign count_inc  = (ent_q.count == psrl_pkg::COUNT_MAX) ? ent_q.count
                                                           : ent_q.count + 1'b1;

  assign new_entry.address     = src_q;
  assign new_entry.count       = psrl_pkg::COUNT_ONE;
  assign new_entry.window_base = now_q;
  assign new_entry.ban_end     = '0;

  // Shared unit and table port steering, by sequencer step.
  always_comb begin
    alu_op         = psrl_pkg::ALU_SUB;
    alu_a          = ram_rdata.address;
    alu_b          = src_q;
    ram_ctl.wr_en  = 1'b0;
    ram_ctl.rd_en  = 1'b0;
    ram_ctl.wr_idx = hit_idx_q;
    ram_ctl.rd_idx = scan_q[psrl_pkg::IDX_W-1:0];
    ram_wdata      = ent_q;
    case (state_q)
      ST_SEARCH: begin
        ram_ctl.rd_en = !match && scan_more;
      end
      ST_BAN_CHK: begin
        alu_a = now_q;
        alu_b = ent_q.ban_end;
      end
      ST_AGE: begin
        alu_a = now_q;
        alu_b = ent_q.window_base;
      end
      ST_WIN_CHK: begin
        alu_a = window_q;
        alu_b = diff_q;
      end
      ST_LIMIT_CHK: begin
        alu_a = psrl_pkg::TIME_W'(max_q);
        alu_b = psrl_pkg::TIME_W'(ent_q.count);
      end
      ST_BAN_SET: begin
        alu_op = psrl_pkg::ALU_ADD;
        alu_a  = now_q;
        alu_b  = ban_ms_q;
      end
      ST_WRITE: begin
        ram_ctl.wr_en = 1'b1;
      end
      ST_INSERT: begin
        ram_ctl.wr_en  = !table_full;
        ram_ctl.wr_idx = fill_q[psrl_pkg::IDX_W-1:0];
        ram_wdata      = new_entry;
      end
      default: begin
      end
    endcase
  end

  psrl_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  psrl_entry_ram u_ram (
    .clk_i     (clk_i),
    .ctl_i     (ram_ctl),
    .wr_data_i (ram_wdata),
    .rd_data_o (ram_rdata)
  );

  // Sequencer: state, fill count, scan pointer and the registered decision.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      allowed_q   <= 1'b0;
      banned_q    <= 1'b0;
      untracked_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            scan_q  <= '0;
            pend_q  <= 1'b0;
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (match) begin
            pend_q  <= 1'b0;
            state_q <= ST_BAN_CHK;
          end else if (scan_more) begin
            pend_q <= 1'b1;
            scan_q <= scan_q + 1'b1;
          end else begin
            pend_q  <= 1'b0;
            state_q <= ST_INSERT;
          end
        end
        ST_BAN_CHK: begin
          if (alu_res.borrow) begin
            // Still banned: refuse without touching the entry.
            allowed_q   <= 1'b0;
            banned_q    <= 1'b0;
            untracked_q <= 1'b0;
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end else begin
            state_q <= ST_AGE;
          end
        end
        ST_AGE: begin
          state_q <= ST_WIN_CHK;
        end
        ST_WIN_CHK: begin
          if (alu_res.borrow) begin
            allowed_q   <= 1'b1;
            banned_q    <= 1'b0;
            untracked_q <= 1'b0;
            state_q     <= ST_WRITE;
          end else begin
            state_q <= ST_LIMIT_CHK;
          end
        end
        ST_LIMIT_CHK: begin
          if (alu_res.borrow) begin
            state_q <= ST_BAN_SET;
          end else begin
            allowed_q   <= 1'b1;
            banned_q    <= 1'b0;
            untracked_q <= 1'b0;
            state_q     <= ST_WRITE;
          end
        end
        ST_BAN_SET: begin
          allowed_q   <= 1'b0;
          banned_q    <= 1'b1;
          untracked_q <= 1'b0;
          state_q     <= ST_WRITE;
        end
        ST_WRITE: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT;
        end
        ST_INSERT: begin
          if (!table_full) begin
            fill_q <= fill_q + 1'b1;
          end
          allowed_q   <= 1'b1;
          banned_q    <= 1'b0;
          untracked_q <= table_full;
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: request, matched entry and working values.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid_i) begin
      src_q <= s_axis_tdata_i[psrl_pkg::ADDR_W-1:0];
      now_q <= s_axis_tdata_i[psrl_pkg::ADDR_W +: psrl_pkg::TIME_W];
    end
    if (state_q == ST_SEARCH) begin
      if (match) begin
        ent_q <= ram_rdata;
      end else if (scan_more) begin
        hit_idx_q <= scan_q[psrl_pkg::IDX_W-1:0];
      end
    end
    if (state_q == ST_AGE) begin
      diff_q <= alu_res.sum;
    end
    if (state_q == ST_WIN_CHK) begin
      if (alu_res.borrow) begin
        ent_q.window_base <= now_q;
        ent_q.count       <= psrl_pkg::COUNT_ONE;
      end else begin
        ent_q.count <= count_inc;
      end
    end
    if (state_q == ST_BAN_SET) begin
      ent_q.ban_end <= alu_res.sum;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= psrl_pkg::WINDOW_MS_RST;
      max_q    <= psrl_pkg::MAX_REQUESTS_RST;
      ban_ms_q <= psrl_pkg::BAN_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        psrl_pkg::CFG_WINDOW_MS:    window_q <= cfg_data_i;
        psrl_pkg::CFG_MAX_REQUESTS: max_q    <= cfg_data_i[psrl_pkg::COUNT_W-1:0];
        psrl_pkg::CFG_BAN_MS:       ban_ms_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, untracked_q, banned_q, allowed_q};

`ifndef NO_ASSERTIONS
  // A new request is never taken while a decision is still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("request accepted while a decision is pending");

  // The fill count never runs past the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= psrl_pkg::FILL_W'(psrl_pkg::TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // A request that starts a ban is always refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && banned_q) |-> !allowed_q)
    else $error("newly banned request admitted");

  // An untracked request is admitted and only happens with a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && untracked_q) |-> (allowed_q && table_full))
    else $error("untracked decision without a full table");

  // The fill count grows only by one, and only out of the insert step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |->
      ($past(state_q) == ST_INSERT && fill_q == $past(fill_q) + 1'b1))
    else $error("unexpected fill count change");
`endif

endmodule

[rtl/psrl_alu.sv]
// ----------------------------------------------------------------------------
// psrl_alu
// The one 32-bit add/subtract unit of the limiter. It serves the address
// match, the ban test, the window age and test, the limit test and the ban
// end computation, one use per cycle.
// ----------------------------------------------------------------------------
module psrl_alu (
  input  psrl_pkg::alu_op_e              op_i,
  input  logic [psrl_pkg::TIME_W-1:0]    a_i,
  input  logic [psrl_pkg::TIME_W-1:0]    b_i,
  output psrl_pkg::alu_res_t             res_o
);

  logic                          sub;
  logic [psrl_pkg::TIME_W-1:0]   b_opnd;
  logic [psrl_pkg::TIME_W:0]     total;

  // A subtraction adds the inverted operand plus one; a missing carry is a borrow.
  assign sub    = (op_i == psrl_pkg::ALU_SUB);
  assign b_opnd = sub ? ~b_i : b_i;
  assign total  = {1'b0, a_i} + {1'b0, b_opnd} + (psrl_pkg::TIME_W + 1)'(sub);

  assign res_o.sum    = total[psrl_pkg::TIME_W-1:0];
  assign res_o.borrow = sub & ~total[psrl_pkg::TIME_W];
  assign res_o.zero   = (total[psrl_pkg::TIME_W-1:0] == '0);

endmodule

[rtl/psrl_entry_ram.sv]
// ----------------------------------------------------------------------------
// psrl_entry_ram
// Source table storage: one write port and one read port with registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module psrl_entry_ram (
  input  logic               clk_i,
  input  psrl_pkg::ram_ctl_t ctl_i,
  input  psrl_pkg::entry_t   wr_data_i,
  output psrl_pkg::entry_t   rd_data_o
);

  psrl_pkg::entry_t mem [psrl_pkg::TABLE_DEPTH];
  psrl_pkg::entry_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.wr_idx] <= wr_data_i;
    end
  end

  // Read port with output register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[ctl_i.rd_idx];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[bench/tb_per_source_rate_limiter_unit.sv]
// ----------------------------------------------------------------------------
// tb_per_source_rate_limiter_unit
// Self-checking bench for the per-source rate limiter. A queue of requests
// feeds a clocked driver, and each accepted request runs through a local
// source table model that predicts its decision. A clocked monitor compares
// every decision leaving the block with the oldest prediction. The run covers
// directed corner cases first. It then saturates one source's count and
// fills the source table through random phases with varied register
// settings and handshake idling.
// ----------------------------------------------------------------------------
module tb_per_source_rate_limiter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import psrl_pkg::*;

  // Index 3 has no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_PAD      = 16;
  localparam int PHASES         = 8;
  localparam int PHASE_REQUESTS = 35;
  localparam int HOT_REQUESTS   = 258;
  localparam int FILL_TARGET    = 264;

  // Idling modes.
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  typedef struct packed {
    logic untracked;
    logic newly_banned;
    logic allowed;
  } decision_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 req_valid = 1'b0;
  logic [63:0]          req_data  = '0;
  logic                 req_ready;
  logic                 dec_valid;
  logic                 dec_ready = 1'b0;
  logic [7:0]           dec_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data  = '0;

  // Local copy of the source table and the registers.
  entry_t             src_table [TABLE_DEPTH];
  int unsigned        table_fill      = 0;
  logic [TIME_W-1:0]  window_ms_q     = WINDOW_MS_RST;
  logic [COUNT_W-1:0] max_requests_q  = MAX_REQUESTS_RST;
  logic [TIME_W-1:0]  ban_ms_q        = BAN_MS_RST;

  logic [63:0]        pending_requests   [$];
  decision_t          expected_decisions [$];
  logic [ADDR_W-1:0]  source_pool        [$];
  logic [TIME_W-1:0]  clock_ms = '0;

  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles      = 0;
  int mismatch_count    = 0;
  int requests_accepted = 0;
  int decisions_checked = 0;
  int refused_count     = 0;
  int ban_count         = 0;
  int untracked_count   = 0;
  int cfg_write_count   = 0;

  per_source_rate_limiter_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (req_ready),
    .s_axis_tdata_i  (req_data),
    .m_axis_tvalid_o (dec_valid),
    .m_axis_tready_i (dec_ready),
    .m_axis_tdata_o  (dec_data),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #4 clk = ~clk;

  // Decide one request against the local table and update it.
  function automatic decision_t decide_request(input logic [ADDR_W-1:0] source,
                                               input logic [TIME_W-1:0] now);
    decision_t         d;
    int                hit;
    logic [TIME_W-1:0] elapsed;
    d = '0;
    d.allowed = 1'b1;
    hit = -1;
    for (int k = 0; k < table_fill; k++) begin
      if (hit < 0 && src_table[k].address == source) hit = k;
    end
    if (hit >= 0) begin
      elapsed = now - src_table[hit].window_base;
      if (src_table[hit].ban_end > now) begin
        // Still banned; a plain comparison, the ban end does not wrap here.
        d.allowed = 1'b0;
      end else if (elapsed > window_ms_q) begin
        src_table[hit].window_base = now;
        src_table[hit].count = COUNT_ONE;
      end else begin
        if (src_table[hit].count != COUNT_MAX) src_table[hit].count++;
        if (src_table[hit].count > max_requests_q) begin
          src_table[hit].ban_end = now + ban_ms_q;
          d.allowed = 1'b0;
          d.newly_banned = 1'b1;
        end
      end
    end else if (table_fill < TABLE_DEPTH) begin
      src_table[table_fill] = '{address: source, count: COUNT_ONE,
                                window_base: now, ban_end: '0};
      table_fill++;
    end else begin
      d.untracked = 1'b1;
    end
    return d;
  endfunction

  // Driver: register writes reach the model, accepted requests get a
  // prediction, and the next item is offered when the slot is free.
  always @(posedge clk) begin
    decision_t d;
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_write_count++;
        case (cfg_index)
          CFG_WINDOW_MS:    window_ms_q = cfg_data;
          CFG_MAX_REQUESTS: max_requests_q = cfg_data[COUNT_W-1:0];
          CFG_BAN_MS:       ban_ms_q = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        d = decide_request(req_data[31:0], req_data[63:32]);
        expected_decisions.push_back(d);
        requests_accepted++;
        if (!d.allowed) refused_count++;
        if (d.newly_banned) ban_count++;
        if (d.untracked) untracked_count++;
      end
      if (!req_valid || req_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          req_data  <= pending_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    decision_t want;
    decision_t got;
    if (!rst_n) begin
      dec_ready <= 1'b0;
    end else begin
      dec_ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (dec_valid && dec_ready) begin
        got = dec_data[2:0];
        decisions_checked++;
        if (expected_decisions.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected decision %0d: allowed=%b banned=%b untracked=%b",
                     decisions_checked, got.allowed, got.newly_banned, got.untracked);
        end else begin
          want = expected_decisions.pop_front();
          if (got.allowed !== want.allowed || got.newly_banned !== want.newly_banned ||
              got.untracked !== want.untracked) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"Decision %0d mismatch: expected allowed=%b banned=%b ",
                        "untracked=%b, got allowed=%b banned=%b untracked=%b"},
                       decisions_checked, want.allowed, want.newly_banned,
                       want.untracked, got.allowed, got.newly_banned, got.untracked);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (req_valid && req_ready) || (dec_valid && dec_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Stalled for %0d cycles with %0d decisions outstanding.",
                 WATCHDOG_LIMIT, expected_decisions.size());
        $display("tb_per_source_rate_limiter_unit: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [TIME_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_request(input logic [ADDR_W-1:0] source,
                             input logic [TIME_W-1:0] stamp);
    pending_requests.push_back({stamp, source});
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      IDLE_SENDER:   begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
      IDLE_BOTH:     begin sender_idle_pct = 6;  receiver_stall_pct = 6;  end
      default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
    endcase
  endtask

  // Returns once every queued request has been decided and taken.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || req_valid || expected_decisions.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Fresh sources dominate until the table has overflowed; after that a few
  // recent sources are hit repeatedly. The clock mostly runs forward, with
  // occasional jumps.
  task automatic queue_random_requests(input int count, input int step_max);
    logic [ADDR_W-1:0] source;
    int                new_pct;
    int                tracked;
    int                recent;
    for (int n = 0; n < count; n++) begin
      new_pct = (source_pool.size() < FILL_TARGET) ? 95 : 20;
      tracked = (source_pool.size() < TABLE_DEPTH) ? source_pool.size() : TABLE_DEPTH;
      recent  = (tracked < 6) ? tracked : 6;
      if (tracked == 0 || $urandom_range(99) < new_pct) begin
        source = $urandom;
        source_pool.push_back(source);
      end else if ($urandom_range(99) < 70) begin
        source = source_pool[tracked - 1 - $urandom_range(recent - 1)];
      end else begin
        source = source_pool[$urandom_range(source_pool.size() - 1)];
      end
      if ($urandom_range(99) < 12) clock_ms = $urandom;
      else clock_ms += $urandom_range(step_max);
      add_request(source, clock_ms);
    end
  endtask

  initial begin
    int kind;
    int step_max;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    // A write to the spare index must leave the defaults in place.
    write_reg(CFG_SPARE, '1);

    // Directed part under the default settings.
    source_pool.push_back(32'h0000_0000);
    source_pool.push_back(32'hFFFF_FFFF);
    source_pool.push_back(32'h0A00_0001);
    source_pool.push_back(32'hC0A8_0001);
    // Count to the limit, get banned, stay refused, then come back exactly at
    // the ban end, where the window has also run out.
    add_request(32'h0000_0000, 32'd0);
    add_request(32'h0000_0000, 32'd1);
    add_request(32'h0000_0000, 32'd2);
    add_request(32'h0000_0000, 32'd3);
    add_request(32'h0000_0000, 32'd5);
    add_request(32'h0000_0000, 32'd10003);
    // Elapsed time across the clock wrap.
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(32'hFFFF_FFFF, 32'd2);
    // Elapsed time equal to the window keeps it; a request well past it restarts it.
    add_request(32'h0A00_0001, 32'd100);
    add_request(32'h0A00_0001, 32'd5100);
    add_request(32'h0A00_0001, 32'd10101);
    // A ban end that wraps past zero does not hold off the next request,
    // which is banned again inside the same window.
    repeat (4) add_request(32'hC0A8_0001, 32'hFFFF_F000);
    add_request(32'hC0A8_0001, 32'hFFFF_F001);
    add_request(32'hC0A8_0001, 32'h0000_0100);
    wait_idle();

    // Widest window and limit: one source's count saturates and is never
    // banned. Lowering the limit below the saturated count bans it.
    write_reg(CFG_WINDOW_MS, '1);
    write_reg(CFG_MAX_REQUESTS, TIME_W'(COUNT_MAX));
    write_reg(CFG_BAN_MS, '1);
    set_idling(IDLE_SENDER);
    clock_ms = 32'h0010_0000;
    repeat (HOT_REQUESTS) begin
      clock_ms += $urandom_range(60);
      add_request(32'h0000_0000, clock_ms);
    end
    wait_idle();
    write_reg(CFG_MAX_REQUESTS, TIME_W'(COUNT_MAX - 1));
    repeat (3) begin
      clock_ms += $urandom_range(1, 60);
      add_request(32'h0000_0000, clock_ms);
    end
    wait_idle();

    // Random phases; the table fills up along the way.
    for (int ph = 0; ph < PHASES; ph++) begin
      kind = ph % 4;
      case (kind)
        0: begin
          write_reg(CFG_WINDOW_MS, $urandom_range(200));
          write_reg(CFG_MAX_REQUESTS, $urandom_range(5));
          write_reg(CFG_BAN_MS, $urandom_range(300));
          step_max = 40;
        end
        1: begin
          write_reg(CFG_WINDOW_MS, '0);
          write_reg(CFG_MAX_REQUESTS, '0);
          write_reg(CFG_BAN_MS, '0);
          step_max = 3;
        end
        2: begin
          write_reg(CFG_WINDOW_MS, $urandom);
          write_reg(CFG_MAX_REQUESTS, $urandom_range(255));
          write_reg(CFG_BAN_MS, $urandom);
          write_reg(CFG_SPARE, $urandom);
          step_max = 60;
        end
        default: begin
          write_reg(CFG_WINDOW_MS, $urandom_range(300));
          write_reg(CFG_MAX_REQUESTS, $urandom_range(1, 4));
          write_reg(CFG_BAN_MS, '1);
          step_max = 40;
        end
      endcase
      set_idling((ph + ph / 4) % 4);
      queue_random_requests(PHASE_REQUESTS, step_max);
      wait_idle();
    end

    repeat (DRAIN_PAD) @(posedge clk);
    $display("Checked %0d decisions for %0d requests: %0d refused, %0d bans, %0d untracked.",
             decisions_checked, requests_accepted, refused_count, ban_count,
             untracked_count);
    $display("Source table held %0d of %0d entries after %0d register writes.",
             table_fill, TABLE_DEPTH, cfg_write_count);
    if (mismatch_count == 0) begin
      $display("tb_per_source_rate_limiter_unit: PASS");
    end else begin
      $display("%0d decisions did not match.", mismatch_count);
      $display("tb_per_source_rate_limiter_unit: FAIL");
    end
    $finish;
  end

endmodule
